// ===== sv/utf8d_pkg.sv =====
// Package for the UTF-8 stream decoder: word and result types, constants,
// and the lead byte decode function. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package utf8d_pkg;

  localparam int CpWidth  = 31;
  localparam int LenWidth = 3;

  localparam logic STATUS_OK    = 1'b0;
  localparam logic STATUS_ERROR = 1'b1;

  localparam logic [7:0] LEAD_2_BASE   = 8'hc0;
  localparam logic [7:0] LEAD_3_BASE   = 8'he0;
  localparam logic [7:0] LEAD_4_BASE   = 8'hf0;
  localparam logic [7:0] LEAD_5_BASE   = 8'hf8;
  localparam logic [7:0] LEAD_6_BASE   = 8'hfc;
  localparam logic [7:0] LEAD_BAD_BASE = 8'hfe;
  localparam logic [7:0] ASCII_LIMIT   = 8'h80;
  localparam logic [7:0] CONT_MASK     = 8'hc0;
  localparam logic [7:0] CONT_PATTERN  = 8'h80;
  localparam logic [7:0] PAYLOAD_MASK  = 8'h3f;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_data;
  } in_word_t;

  typedef struct packed {
    logic [CpWidth-1:0]  code_point;
    logic [LenWidth-1:0] seq_length;
    logic                status;
  } result_t;

  typedef struct packed {
    logic [LenWidth-1:0] length;
    logic [7:0]          bits;
  } lead_info_t;

  // Sequence length and value bits of a multi-byte lead byte (C0 to FD).
  function automatic lead_info_t lead_decode(input logic [7:0] b);
    lead_info_t info;
    info.length = LenWidth'(2);
    info.bits   = b & 8'h1f;
    if (b >= LEAD_6_BASE) begin
      info.length = LenWidth'(6);
      info.bits   = b & 8'h01;
    end else if (b >= LEAD_5_BASE) begin
      info.length = LenWidth'(5);
      info.bits   = b & 8'h03;
    end else if (b >= LEAD_4_BASE) begin
      info.length = LenWidth'(4);
      info.bits   = b & 8'h07;
    end else if (b >= LEAD_3_BASE) begin
      info.length = LenWidth'(3);
      info.bits   = b & 8'h0f;
    end
    return info;
  endfunction

endpackage
`default_nettype wire

// ===== sv/utf8d_in_stage.sv =====
// Input register of the UTF-8 stream decoder: holds one accepted word until
// the decode stage takes it. Depends on utf8d_pkg.
`timescale 1ns / 1ps
`default_nettype none
module utf8d_in_stage (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire utf8d_pkg::in_word_t in_word,
  input  wire logic               advance,
  output logic                    fire,
  output utf8d_pkg::in_word_t     held_word
);
  import utf8d_pkg::*;

  logic held_valid;
  logic held_valid_next;
  logic accept;

  assign in_stall = held_valid && !advance;
  assign accept   = in_valid && !in_stall;
  assign fire     = held_valid && advance;

  always_comb begin
    held_valid_next = held_valid;
    if (accept) begin
      held_valid_next = 1'b1;
    end else if (advance) begin
      held_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else begin
      held_valid <= held_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      held_word <= in_word;
    end
  end

endmodule
`default_nettype wire

// ===== sv/utf8d_decode.sv =====
// Decode stage of the UTF-8 stream decoder: sequence state and the per-word
// combinational decode. Depends on utf8d_pkg.
`timescale 1ns / 1ps
`default_nettype none
module utf8d_decode (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                fire,
  input  wire utf8d_pkg::in_word_t word,
  output logic                     res_valid,
  output utf8d_pkg::result_t       res
);
  import utf8d_pkg::*;

  logic [CpWidth-1:0]  partial_value;
  logic [LenWidth-1:0] bytes_remaining;
  logic [LenWidth-1:0] sequence_length;
  logic [CpWidth-1:0]  partial_value_next;
  logic [LenWidth-1:0] bytes_remaining_next;
  logic [LenWidth-1:0] sequence_length_next;
  lead_info_t          lead;
  logic [CpWidth-1:0]  shifted;
  logic [LenWidth-1:0] remaining_dec;

  assign lead          = lead_decode(word.data_byte);
  assign shifted       = {partial_value[CpWidth-7:0], word.data_byte[5:0]};
  assign remaining_dec = bytes_remaining - LenWidth'(1);

  always_comb begin
    partial_value_next   = partial_value;
    bytes_remaining_next = bytes_remaining;
    sequence_length_next = sequence_length;
    res_valid            = 1'b0;
    res.code_point       = '0;
    res.seq_length       = '0;
    res.status           = STATUS_ERROR;
    if (bytes_remaining == '0) begin
      if (word.data_byte < ASCII_LIMIT) begin
        res_valid      = 1'b1;
        res.code_point = CpWidth'(word.data_byte);
        res.seq_length = LenWidth'(1);
        res.status     = STATUS_OK;
      end else if (word.data_byte >= LEAD_BAD_BASE || word.data_byte < LEAD_2_BASE ||
                   word.end_of_data) begin
        res_valid = 1'b1;
      end else begin
        partial_value_next   = CpWidth'(lead.bits);
        bytes_remaining_next = lead.length - LenWidth'(1);
        sequence_length_next = lead.length;
      end
    end else if ((word.data_byte & CONT_MASK) != CONT_PATTERN) begin
      res_valid            = 1'b1;
      partial_value_next   = '0;
      bytes_remaining_next = '0;
      sequence_length_next = '0;
    end else if (remaining_dec == '0) begin
      res_valid            = 1'b1;
      res.code_point       = shifted;
      res.seq_length       = sequence_length;
      res.status           = STATUS_OK;
      partial_value_next   = '0;
      bytes_remaining_next = '0;
      sequence_length_next = '0;
    end else if (word.end_of_data) begin
      res_valid            = 1'b1;
      partial_value_next   = '0;
      bytes_remaining_next = '0;
      sequence_length_next = '0;
    end else begin
      partial_value_next   = shifted;
      bytes_remaining_next = remaining_dec;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      partial_value   <= '0;
      bytes_remaining <= '0;
      sequence_length <= '0;
    end else if (fire) begin
      partial_value   <= partial_value_next;
      bytes_remaining <= bytes_remaining_next;
      sequence_length <= sequence_length_next;
    end
  end

  // Any result closes the open sequence.
  assert property (@(posedge clk) disable iff (rst)
    fire && res_valid |=> bytes_remaining == '0)
    else $error("sequence still open after a result");

  assert property (@(posedge clk) disable iff (rst)
    bytes_remaining < sequence_length || bytes_remaining == '0)
    else $error("remaining count not below sequence length");

  assert property (@(posedge clk) disable iff (rst)
    res_valid && res.status == STATUS_OK |-> res.seq_length != '0)
    else $error("valid result with zero length");

  assert property (@(posedge clk) disable iff (rst)
    res_valid && res.status == STATUS_ERROR |-> res.code_point == '0 && res.seq_length == '0)
    else $error("error result carries a value");

endmodule
`default_nettype wire

// ===== sv/utf8d_out_stage.sv =====
// Result register of the UTF-8 stream decoder: holds one result until the
// downstream side takes it. Depends on utf8d_pkg.
`timescale 1ns / 1ps
`default_nettype none
module utf8d_out_stage (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               fire,
  input  wire logic               res_valid,
  input  wire utf8d_pkg::result_t res,
  output logic                    advance,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output utf8d_pkg::result_t      out_res
);
  import utf8d_pkg::*;

  logic out_valid_next;
  logic load;

  assign advance = !out_valid || !out_stall;
  assign load    = fire && res_valid;

  always_comb begin
    out_valid_next = out_valid;
    if (advance) begin
      out_valid_next = load;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_res <= res;
    end
  end

endmodule
`default_nettype wire

// ===== sv/utf8_stream_decoder_top.sv =====
// Top level of the UTF-8 stream decoder: input register, decode stage and
// result register. Depends on utf8d_pkg and the three utf8d stages.
// Path: the last byte of a sequence passes the input register and the decode stage, and its result is then registered.
// Throughput: one byte per cycle while the downstream side does not stall, set by the single decode stage.
// Reset: synchronous; clears the open sequence and both stage valid flags.
`timescale 1ns / 1ps
`default_nettype none
module utf8_stream_decoder_top (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  data_byte,
  input  wire logic        end_of_data,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [30:0]      code_point,
  output logic [2:0]       seq_length,
  output logic             status
);
  import utf8d_pkg::*;

  in_word_t in_word;
  in_word_t held_word;
  result_t  res;
  result_t  out_res;
  logic     advance;
  logic     fire;
  logic     res_valid;

  assign in_word.data_byte   = data_byte;
  assign in_word.end_of_data = end_of_data;

  utf8d_in_stage u_in (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .advance   (advance),
    .fire      (fire),
    .held_word (held_word)
  );

  utf8d_decode u_decode (
    .clk       (clk),
    .rst       (rst),
    .fire      (fire),
    .word      (held_word),
    .res_valid (res_valid),
    .res       (res)
  );

  utf8d_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .fire      (fire),
    .res_valid (res_valid),
    .res       (res),
    .advance   (advance),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (out_res)
  );

  assign code_point = out_res.code_point;
  assign seq_length = out_res.seq_length;
  assign status     = out_res.status;

endmodule
`default_nettype wire
